// ===== rtl/sfpa_pkg.sv =====
`default_nettype none

package sfpa_pkg;

  // Command codes on the request channel.
  localparam logic [1:0] REQ_BEGIN_STRIP = 2'd0;
  localparam logic [1:0] REQ_BEGIN_FAN   = 2'd1;
  localparam logic [1:0] REQ_VERTEX      = 2'd2;
  localparam logic [1:0] REQ_END         = 2'd3;

  // Primitive mode codes.
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_STRIP = 2'd1;
  localparam logic [1:0] MODE_FAN   = 2'd2;

  // Vertex count saturates once a triangle can be closed.
  localparam logic [1:0] SEEN_FULL = 2'd2;

  // Corner positions within a triangle.
  localparam logic [1:0] CORNER_FIRST = 2'd0;
  localparam logic [1:0] CORNER_LAST  = 2'd2;

  // Result status codes.
  localparam logic STATUS_CORNER = 1'b0;
  localparam logic STATUS_ERROR  = 1'b1;

  // Control from the command decoder to the result stage.
  typedef struct packed {
    logic fire;   // this transaction produces results
    logic err;    // the result is a single sequence error
  } sfpa_load_t;

endpackage

`default_nettype wire

// ===== rtl/sfpa_req_if.sv =====
`default_nettype none

interface sfpa_req_if #(
  parameter int TAG_WIDTH = 16
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [TAG_WIDTH-1:0] vertex_tag;

  modport source (output valid, output req_type, output vertex_tag, input ready);
  modport sink   (input valid, input req_type, input vertex_tag, output ready);
endinterface

`default_nettype wire

// ===== rtl/sfpa_res_if.sv =====
`default_nettype none

interface sfpa_res_if #(
  parameter int TAG_WIDTH = 16
);
  logic                 valid;
  logic                 ready;
  logic [TAG_WIDTH-1:0] out_tag;
  logic [1:0]           corner;
  logic                 last_corner;
  logic                 status;

  modport source (output valid, output out_tag, output corner, output last_corner,
                  output status, input ready);
  modport sink   (input valid, input out_tag, input corner, input last_corner,
                  input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/sfpa_step.sv =====
`default_nettype none

module sfpa_step #(
  parameter int TAG_WIDTH = 16
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     accept,
  input  wire [1:0]               req_type,
  input  wire [TAG_WIDTH-1:0]     vertex_tag,
  output sfpa_pkg::sfpa_load_t    load,
  output logic [TAG_WIDTH-1:0]    vtx0,
  output logic [TAG_WIDTH-1:0]    vtx1,
  output logic [TAG_WIDTH-1:0]    vtx2
);
  import sfpa_pkg::*;

  logic [1:0]           prim_mode;
  logic [1:0]           prim_mode_next;
  logic [TAG_WIDTH-1:0] first_tag;
  logic [TAG_WIDTH-1:0] first_tag_next;
  logic [TAG_WIDTH-1:0] older_tag;
  logic [TAG_WIDTH-1:0] older_tag_next;
  logic [TAG_WIDTH-1:0] newer_tag;
  logic [TAG_WIDTH-1:0] newer_tag_next;
  logic [1:0]           seen_count;
  logic [1:0]           seen_count_next;
  logic                 odd_triangle;
  logic                 odd_triangle_next;

  always_comb begin
    prim_mode_next    = prim_mode;
    first_tag_next    = first_tag;
    older_tag_next    = older_tag;
    newer_tag_next    = newer_tag;
    seen_count_next   = seen_count;
    odd_triangle_next = odd_triangle;
    load              = '0;
    vtx0              = older_tag;
    vtx1              = newer_tag;
    vtx2              = vertex_tag;

    case (req_type)
      REQ_BEGIN_STRIP, REQ_BEGIN_FAN: begin
        if (prim_mode != MODE_IDLE) begin
          load.fire = 1'b1;
          load.err  = 1'b1;
        end else begin
          prim_mode_next    = (req_type == REQ_BEGIN_STRIP) ? MODE_STRIP : MODE_FAN;
          seen_count_next   = '0;
          odd_triangle_next = 1'b0;
        end
      end
      REQ_VERTEX: begin
        if (prim_mode == MODE_IDLE) begin
          load.fire = 1'b1;
          load.err  = 1'b1;
        end else begin
          if (seen_count == '0) begin
            first_tag_next = vertex_tag;
          end
          if (seen_count == SEEN_FULL) begin
            load.fire = 1'b1;
            if (prim_mode == MODE_STRIP) begin
              // odd strip triangles reverse the winding
              if (odd_triangle) begin
                vtx0 = vertex_tag;
                vtx2 = older_tag;
              end
              odd_triangle_next = ~odd_triangle;
            end else begin
              vtx0 = first_tag;
            end
          end else begin
            seen_count_next = seen_count + 2'd1;
          end
          older_tag_next = newer_tag;
          newer_tag_next = vertex_tag;
        end
      end
      default: begin
        if (prim_mode == MODE_IDLE) begin
          load.fire = 1'b1;
          load.err  = 1'b1;
        end else begin
          prim_mode_next    = MODE_IDLE;
          seen_count_next   = '0;
          odd_triangle_next = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prim_mode    <= MODE_IDLE;
      first_tag    <= '0;
      older_tag    <= '0;
      newer_tag    <= '0;
      seen_count   <= '0;
      odd_triangle <= 1'b0;
    end else if (accept) begin
      prim_mode    <= prim_mode_next;
      first_tag    <= first_tag_next;
      older_tag    <= older_tag_next;
      newer_tag    <= newer_tag_next;
      seen_count   <= seen_count_next;
      odd_triangle <= odd_triangle_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sfpa_emit.sv =====
`default_nettype none

module sfpa_emit #(
  parameter int TAG_WIDTH = 16
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     accept,
  input  wire sfpa_pkg::sfpa_load_t load,
  input  wire [TAG_WIDTH-1:0]     vtx0,
  input  wire [TAG_WIDTH-1:0]     vtx1,
  input  wire [TAG_WIDTH-1:0]     vtx2,
  output logic                    free,
  sfpa_res_if.source              res
);
  import sfpa_pkg::*;

  logic                 held;
  logic [1:0]           idx;
  logic                 is_err;
  logic [TAG_WIDTH-1:0] tag0;
  logic [TAG_WIDTH-1:0] tag1;
  logic [TAG_WIDTH-1:0] tag2;
  logic                 last;
  logic                 take;

  assign last = is_err || (idx == CORNER_LAST);
  assign take = held && res.ready;
  // buffer can take a new triangle once its final corner leaves
  assign free = !held || (res.ready && last);

  always_comb begin
    case (idx)
      2'd0:    res.out_tag = tag0;
      2'd1:    res.out_tag = tag1;
      default: res.out_tag = tag2;
    endcase
    if (is_err) begin
      res.out_tag = '0;
    end
  end

  assign res.valid       = held;
  assign res.corner      = idx;
  assign res.last_corner = last;
  assign res.status      = is_err ? STATUS_ERROR : STATUS_CORNER;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      idx  <= CORNER_FIRST;
    end else if (accept && load.fire) begin
      held <= 1'b1;
      idx  <= CORNER_FIRST;
    end else if (take) begin
      if (last) begin
        held <= 1'b0;
        idx  <= CORNER_FIRST;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && load.fire) begin
      is_err <= load.err;
      tag0   <= vtx0;
      tag1   <= vtx1;
      tag2   <= vtx2;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/strip_fan_primitive_assembler_core.sv =====
`default_nettype none

// Triangle strip and fan primitive assembler. Commands arrive on req
// (begin strip, begin polygon, vertex, end) and leave on res as a plain
// triangle list, one corner per transaction, corners 0..2 with last_corner
// on corner 2. Strips alternate winding, (v0,v1,v2), (v3,v2,v1), ...;
// polygons fan around their first vertex. A begin while a primitive is
// open, or a vertex or end while idle, yields a single error transaction
// (status 1, out_tag 0, last_corner 1) and leaves the state alone.
// A command is decoded in the cycle it is accepted. A vertex that closes
// a triangle occupies the result buffer until its three corners have
// left, one per transaction as res.ready allows, and no further command
// is taken meanwhile. Commands that produce nothing are taken every cycle
// while the buffer is free, and the next command is taken in the same
// cycle the final corner of the previous triangle leaves. The first
// corner is presented in the cycle after accept.
module strip_fan_primitive_assembler_core #(
  parameter int TAG_WIDTH = 16
) (
  input  wire        clk,
  input  wire        rst,
  sfpa_req_if.sink   req,
  sfpa_res_if.source res
);
  import sfpa_pkg::*;

  sfpa_load_t           load;
  logic [TAG_WIDTH-1:0] vtx0;
  logic [TAG_WIDTH-1:0] vtx1;
  logic [TAG_WIDTH-1:0] vtx2;
  logic                 free;
  logic                 accept;

  // Take a command whenever the result buffer has room for what it makes.
  assign req.ready = free;
  assign accept    = req.valid && free;

  // Decode the command against the primitive state and build the triangle.
  sfpa_step #(
    .TAG_WIDTH (TAG_WIDTH)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .req_type   (req.req_type),
    .vertex_tag (req.vertex_tag),
    .load       (load),
    .vtx0       (vtx0),
    .vtx1       (vtx1),
    .vtx2       (vtx2)
  );

  // Hold the triangle (or error) and send it out one corner at a time.
  sfpa_emit #(
    .TAG_WIDTH (TAG_WIDTH)
  ) u_emit (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .load   (load),
    .vtx0   (vtx0),
    .vtx1   (vtx1),
    .vtx2   (vtx2),
    .free   (free),
    .res    (res)
  );

endmodule

`default_nettype wire
